### src/stlbs_pkg.sv
// Package for the sorted table lower-bound search core.
// Holds table sizing constants, operation codes and the payload structs.
// No dependencies.
package stlbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int POS_W       = 11;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [1:0] {
		K_CLEAR,
		K_APPEND,
		K_SEARCH,
		K_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [DATA_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             status;
	} rsp_item_t;

	typedef struct packed {
		cmd_kind_t                kind;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

### src/stlbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stlbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/stlbs_front.sv
// Front end: accepts request transactions, classifies them and queues them.
// Depends on stlbs_pkg.
module stlbs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  stlbs_pkg::req_item_t req,
	output logic                cmd_valid,
	output stlbs_pkg::cmd_t     cmd,
	input  logic                pop
);
	import stlbs_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       take;
	cmd_t       cls;

	always_comb begin
		cls.value = req.value;
		unique case (req.operation)
			OP_CLEAR:  cls.kind = K_CLEAR;
			OP_APPEND: cls.kind = K_APPEND;
			OP_SEARCH: cls.kind = K_SEARCH;
			default:   cls.kind = K_NOP;
		endcase
	end

	assign req_stall = (fill_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign take      = pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !take) begin
				fill_q <= fill_q + 2'd1;
			end else if (take && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

### src/stlbs_back.sv
// Back end: executes queued commands against the table and drives the result register.
// Depends on stlbs_pkg and stlbs_ram.
module stlbs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  stlbs_pkg::cmd_t      cmd,
	output logic                 pop,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output stlbs_pkg::rsp_item_t rsp
);
	import stlbs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PROBE = 3'b010,
		S_CMP   = 3'b100
	} state_t;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [CNT_W-1:0]         lo_q, lo_d;
	logic [CNT_W-1:0]         hi_q, hi_d;
	logic signed [DATA_W-1:0] target_q, target_d;
	logic                     out_valid_q;
	rsp_item_t                out_q;
	logic                     out_free;
	logic                     res_load;
	rsp_item_t                res_d;
	logic [CNT_W-1:0]         mid;
	logic                     ram_we;
	logic [DATA_W-1:0]        ram_rdata;

	assign out_free = !out_valid_q || !rsp_stall;
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	stlbs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(cmd.value),
		.raddr(mid[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		target_d = target_q;
		pop      = 1'b0;
		ram_we   = 1'b0;
		res_load = 1'b0;
		res_d    = '{position: '0, status: ST_OK};
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.kind == K_SEARCH) begin
					pop      = 1'b1;
					target_d = cmd.value;
					lo_d     = '0;
					hi_d     = count_q;
					state_d  = S_PROBE;
				end else if (cmd_valid && out_free) begin
					pop      = 1'b1;
					res_load = 1'b1;
					unique case (cmd.kind)
						K_CLEAR: begin
							count_d = '0;
						end
						K_APPEND: begin
							res_d.position = POS_W'(count_q);
							if (count_q < CNT_W'(TABLE_DEPTH)) begin
								ram_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end else begin
								res_d.status = ST_FULL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_PROBE: begin
				if (lo_q < hi_q) begin
					state_d = S_CMP;
				end else if (out_free) begin
					res_load       = 1'b1;
					res_d.position = POS_W'(lo_q);
					state_d        = S_IDLE;
				end
			end
			S_CMP: begin
				if ($signed(ram_rdata) >= target_q) begin
					hi_d = mid;
				end else begin
					lo_d = mid + CNT_W'(1);
				end
				state_d = S_PROBE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		target_q <= target_d;
		if (res_load) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

### src/sorted_table_lower_bound_search_core.sv
// Top level of the sorted table lower-bound search core.
// Depends on stlbs_pkg, stlbs_front and stlbs_back.
//
// Request channel (req_valid, req_stall, req): one transaction carries an
// operation (clear, append, search) and a signed 32-bit value. Requests enter
// a two-entry queue, so up to two may be taken while the back end is busy.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one transaction per
// request, in request order, with position and status.
// Clear, append and unused codes are answered straight from the idle state.
// Search repeats a probe of the table RAM (registered read, then compare)
// as a binary search until its bounds meet, then loads the lower-bound
// position into the response register.
// Reset clears the entry count, the queue and the response valid flag; the
// table RAM is not cleared and is only ever read below the count.
// While rsp_stall is high the response holds; the back end finishes work
// into the held slot only once it drains, and the queue fills behind it,
// after which req_stall rises.
module sorted_table_lower_bound_search_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  stlbs_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output stlbs_pkg::rsp_item_t rsp
);
	import stlbs_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic pop;

	stlbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (pop)
	);

	stlbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.pop      (pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

### bench/tb_lower_bound_pkg.sv
// Scoreboard for the sorted table lower-bound search core testbench.
// Keeps its own copy of the table and count and queues the awaited responses.
// Depends on stlbs_pkg.
package tb_lower_bound_pkg;

	import stlbs_pkg::*;

	class lower_bound_scoreboard;
		logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
		int unsigned              fill = 0;
		rsp_item_t                awaited_rsp [$];
		int unsigned              mismatches = 0;

		function automatic int unsigned lower_bound(logic signed [DATA_W-1:0] target);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = fill;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (entries[mid] >= target) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
			return lo;
		endfunction

		function void note_request(req_item_t item);
			rsp_item_t exp_rsp;
			exp_rsp.position = '0;
			exp_rsp.status   = ST_OK;
			case (item.operation)
				OP_CLEAR: begin
					fill = 0;
				end
				OP_APPEND: begin
					exp_rsp.position = POS_W'(fill);
					if (fill < TABLE_DEPTH) begin
						entries[fill] = item.value;
						fill++;
					end else begin
						exp_rsp.status = ST_FULL;
					end
				end
				OP_SEARCH: begin
					exp_rsp.position = POS_W'(lower_bound(item.value));
				end
				default: ;
			endcase
			awaited_rsp.push_back(exp_rsp);
		endfunction

		function void check_response(rsp_item_t got);
			rsp_item_t exp_rsp;
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: position %0d status %0d",
						got.position, got.status);
				return;
			end
			exp_rsp = awaited_rsp.pop_front();
			if (got.position !== exp_rsp.position || got.status !== exp_rsp.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response error: expected position %0d status %0d, got position %0d status %0d",
						exp_rsp.position, exp_rsp.status, got.position, got.status);
			end
		endfunction

		function int unsigned pending();
			return awaited_rsp.size();
		endfunction
	endclass

endpackage

### bench/tb_top.sv
// Top-level testbench for sorted_table_lower_bound_search_core.
// Drives clear, append, search and unused-code transactions with random gaps and stalls.
// Depends on stlbs_pkg and tb_lower_bound_pkg.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stlbs_pkg::*;
	import tb_lower_bound_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         SIGNED_MIN = int'(32'h8000_0000);
	localparam int         SIGNED_MAX = int'(32'h7fff_ffff);

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	lower_bound_scoreboard sb = new();
	int unsigned           items_sent = 0;
	bit                    req_quiet = 1'b0;
	int unsigned           stall_left = 0;
	int unsigned           quiet_left = 0;

	sorted_table_lower_bound_search_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if (quiet_left > 0) begin
				quiet_left--;
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				case ($urandom_range(0, 19))
					0: quiet_left = $urandom_range(20, 200);
					1, 2, 3: stall_left = $urandom_range(1, 3);
					4: stall_left = $urandom_range(10, 40);
					default: ;
				endcase
				rsp_stall <= (stall_left > 0);
			end
		end
	end

	function automatic int rand_value();
		case ($urandom_range(0, 5))
			1: return int'($urandom_range(0, 200)) - 100;
			2: return SIGNED_MIN + int'($urandom_range(0, 3));
			3: return SIGNED_MAX - int'($urandom_range(0, 3));
			default: return int'($urandom);
		endcase
	endfunction

	task automatic send_req(input logic [1:0] op, input int val);
		req_item_t   item;
		int unsigned gap;
		item.operation = op;
		item.value     = val;
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
		items_sent++;
		gap = 0;
		if (!req_quiet) begin
			case ($urandom_range(0, 9))
				6, 7, 8: gap = $urandom_range(1, 3);
				9: gap = $urandom_range(10, 40);
				default: gap = 0;
			endcase
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every awaited response has drained
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic probe_table(input int unsigned n_append, input bit clear_first,
			input int unsigned n_search);
		int vals [$];
		int target;
		int idx;
		repeat (n_append) vals.push_back(rand_value());
		vals.sort();
		if (clear_first)
			send_req(OP_CLEAR, rand_value());
		foreach (vals[i])
			send_req(OP_APPEND, vals[i]);
		repeat (n_search) begin
			idx    = (vals.size() != 0) ? $urandom_range(0, vals.size() - 1) : 0;
			target = (vals.size() != 0) ? vals[idx] : rand_value();
			case ($urandom_range(0, 5))
				1: target = target - 1;
				2: target = target + 1;
				3: target = rand_value();
				4: target = SIGNED_MIN;
				5: target = SIGNED_MAX;
				default: ;
			endcase
			send_req(OP_SEARCH, target);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(OP_SEARCH, SIGNED_MIN);
		send_req(OP_SEARCH, SIGNED_MAX);
		send_req(OP_UNUSED, SIGNED_MAX);
		send_req(OP_APPEND, SIGNED_MIN);
		send_req(OP_APPEND, -1);
		send_req(OP_APPEND, 0);
		send_req(OP_APPEND, 0);
		send_req(OP_APPEND, SIGNED_MAX);
		send_req(OP_SEARCH, SIGNED_MIN);
		send_req(OP_SEARCH, SIGNED_MAX);
		send_req(OP_SEARCH, 0);
		send_req(OP_SEARCH, 1);
		send_req(OP_SEARCH, -2);
		send_req(OP_UNUSED, 0);
		drain();
		send_req(OP_CLEAR, 0);
		send_req(OP_SEARCH, 0);
		send_req(OP_APPEND, 5);
		send_req(OP_APPEND, 3);
		send_req(OP_APPEND, 9);
		send_req(OP_SEARCH, 4);
		send_req(OP_SEARCH, 10);
		send_req(OP_CLEAR, SIGNED_MAX);
		send_req(OP_SEARCH, SIGNED_MIN);
		drain();

		// fill the table to the brim, then push past it
		probe_table(TABLE_DEPTH, 1'b1, 30);
		repeat (3) send_req(OP_APPEND, rand_value());
		send_req(OP_SEARCH, SIGNED_MAX);

		while (items_sent < 1800) begin
			req_quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: repeat ($urandom_range(1, 6))
					send_req(2'($urandom_range(0, 3)), rand_value());
				1: probe_table($urandom_range(1, 10), 1'b0, 4);
				2: probe_table($urandom_range(100, 300), 1'b1, 10);
				3: drain();
				default: probe_table($urandom_range(0, 40), 1'b1, $urandom_range(3, 15));
			endcase
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
